// ===== src/ptts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the priority timed task scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;
  localparam int TASK_SLOTS = 16;
  localparam int ID_W = $clog2(TASK_SLOTS);
  localparam int LINK_W = ID_W + 1;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(TASK_SLOTS);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    REQ_ADD = 3'd0, REQ_REMOVE = 3'd1, REQ_TICK = 3'd2,
    REQ_PASS = 3'd3, REQ_SUSPEND = 3'd4, REQ_RESUME = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_OVERRUN = 3'd2,
    ST_EMPTY = 3'd3, ST_BAD_ID = 3'd4, ST_NO_SUSPEND = 3'd5
  } status_t;
endpackage

// ===== src/priority_timed_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_timed_task_scheduler
// Add, remove, tick, suspend and resume each answer with one output word.
// A run pass walks the linked task table one entry per cycle: each pending
// add is merged by a walk of the run list, then one walk for decrement (only
// when a tick is pending), one for service and one for removal.
// One item at a time. Synchronous active-low reset restores the free list.
// ----------------------------------------------------------------------------
module priority_timed_task_scheduler
  import ptts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_task_priority,
  input  logic [15:0]       in_start_delay,
  input  logic [15:0]       in_reload_interval,
  input  logic              in_one_shot,
  input  logic [3:0]        in_target_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_slot_id,
  output logic              out_slot_valid,
  output logic              out_last_of_run,
  output logic [2:0]        out_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_MERGE_POP, S_MERGE_WALK, S_DEC, S_SERVE, S_DROP, S_EMIT, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] interval_r [TASK_SLOTS];
  logic [15:0] timer_r [TASK_SLOTS];
  logic [7:0]  prio_r [TASK_SLOTS];
  logic        once_r [TASK_SLOTS];
  logic        mark_r [TASK_SLOTS];
  logic [LINK_W-1:0] link_r [TASK_SLOTS];
  logic [LINK_W-1:0] run_head_r, pend_head_r, free_head_r;
  logic tick_r, susp_r, resume_r;

  logic [LINK_W-1:0] cur_r, prev_r, nw_r;
  logic [ID_W-1:0] due_q_r [MAX_RESULTS];
  logic [CNT_W-1:0] due_cnt_r, emit_idx_r;

  logic [ID_W-1:0] cur_id, prev_id, nw_id;
  assign cur_id  = cur_r[ID_W-1:0];
  assign prev_id = prev_r[ID_W-1:0];
  assign nw_id   = nw_r[ID_W-1:0];

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < TASK_SLOTS; i++) link_r[i] <= LINK_W'(i + 1);
      run_head_r <= END_MARK;
      pend_head_r <= END_MARK;
      free_head_r <= '0;
      tick_r <= 1'b0;
      susp_r <= 1'b0;
      resume_r <= 1'b0;
      out_valid <= 1'b0;
      due_cnt_r <= '0;
      emit_idx_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            out_slot_id <= '0;
            out_slot_valid <= 1'b0;
            out_last_of_run <= 1'b1;
            out_status <= ST_OK;
            state_r <= S_OUT;
            case (in_req_type)
              REQ_ADD: begin
                if (free_head_r == END_MARK) begin
                  out_status <= ST_FULL;
                end else begin
                  free_head_r <= link_r[free_head_r[ID_W-1:0]];
                  link_r[free_head_r[ID_W-1:0]] <= pend_head_r;
                  pend_head_r <= free_head_r;
                  interval_r[free_head_r[ID_W-1:0]] <= in_reload_interval;
                  timer_r[free_head_r[ID_W-1:0]] <= in_start_delay;
                  prio_r[free_head_r[ID_W-1:0]] <= in_task_priority;
                  once_r[free_head_r[ID_W-1:0]] <= in_one_shot;
                  mark_r[free_head_r[ID_W-1:0]] <= 1'b0;
                  out_slot_id <= free_head_r[ID_W-1:0];
                  out_slot_valid <= 1'b1;
                end
              end
              REQ_REMOVE: begin
                if (run_head_r == END_MARK) out_status <= ST_EMPTY;
                else if ({1'b0, in_target_slot} >= LINK_W'(TASK_SLOTS))
                  out_status <= ST_BAD_ID;
                else mark_r[in_target_slot[ID_W-1:0]] <= 1'b1;
              end
              REQ_TICK: begin
                if (!susp_r) begin
                  if (tick_r) out_status <= ST_OVERRUN;
                  tick_r <= 1'b1;
                end
                if (resume_r) begin
                  if (!susp_r && !tick_r) out_status <= ST_NO_SUSPEND;
                  resume_r <= 1'b0;
                  susp_r <= 1'b0;
                end
              end
              REQ_PASS: begin
                due_cnt_r <= '0;
                state_r <= S_MERGE_POP;
              end
              REQ_SUSPEND: susp_r <= 1'b1;
              REQ_RESUME: resume_r <= 1'b1;
              default: ;
            endcase
          end
        end
        S_MERGE_POP: begin
          if (pend_head_r == END_MARK) begin
            cur_r <= run_head_r;
            state_r <= tick_r ? S_DEC : S_SERVE;
            tick_r <= 1'b0;
          end else begin
            nw_r <= pend_head_r;
            pend_head_r <= link_r[pend_head_r[ID_W-1:0]];
            cur_r <= run_head_r;
            prev_r <= END_MARK;
            state_r <= S_MERGE_WALK;
          end
        end
        S_MERGE_WALK: begin
          if (cur_r != END_MARK && prio_r[nw_id] >= prio_r[cur_id]) begin
            prev_r <= cur_r;
            cur_r <= link_r[cur_id];
          end else begin
            link_r[nw_id] <= cur_r;
            if (prev_r == END_MARK) run_head_r <= nw_r;
            else link_r[prev_id] <= nw_r;
            state_r <= S_MERGE_POP;
          end
        end
        S_DEC: begin
          if (cur_r == END_MARK) begin
            cur_r <= run_head_r;
            state_r <= S_SERVE;
          end else begin
            if (timer_r[cur_id] != '0) timer_r[cur_id] <= timer_r[cur_id] - 16'd1;
            cur_r <= link_r[cur_id];
          end
        end
        S_SERVE: begin
          if (cur_r == END_MARK) begin
            cur_r <= run_head_r;
            prev_r <= END_MARK;
            state_r <= S_DROP;
          end else begin
            if (timer_r[cur_id] == '0) begin
              timer_r[cur_id] <= interval_r[cur_id];
              if (once_r[cur_id]) mark_r[cur_id] <= 1'b1;
              if (due_cnt_r != CNT_W'(MAX_RESULTS)) begin
                due_q_r[due_cnt_r[ID_W-1:0]] <= cur_id;
                due_cnt_r <= due_cnt_r + 1'b1;
              end
            end
            cur_r <= link_r[cur_id];
          end
        end
        S_DROP: begin
          if (cur_r == END_MARK) begin
            emit_idx_r <= '0;
            state_r <= S_EMIT;
          end else begin
            if (mark_r[cur_id]) begin
              if (prev_r == END_MARK) run_head_r <= link_r[cur_id];
              else link_r[prev_id] <= link_r[cur_id];
              link_r[cur_id] <= free_head_r;
              free_head_r <= cur_r;
            end else begin
              prev_r <= cur_r;
            end
            cur_r <= link_r[cur_id];
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_status <= ST_OK;
            if (due_cnt_r == '0) begin
              out_slot_id <= '0;
              out_slot_valid <= 1'b0;
              out_last_of_run <= 1'b1;
              state_r <= S_OUT;
            end else begin
              out_slot_id <= due_q_r[emit_idx_r[ID_W-1:0]];
              out_slot_valid <= 1'b1;
              out_last_of_run <= (emit_idx_r + 1'b1 == due_cnt_r);
              emit_idx_r <= emit_idx_r + 1'b1;
              if (emit_idx_r + 1'b1 == due_cnt_r) state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
